// ===== hdl/ccear_pkg.sv =====
// ----------------------------------------------------------------------------
// ccear_pkg
// Shared types and constants of the echo-and-answer receiver: item structs,
// phase and mode codes, configuration register indexes and store sizes.
// ----------------------------------------------------------------------------
package ccear_pkg;

    // request store geometry
    localparam int REQ_DEPTH = 256;
    localparam int REQ_AW    = $clog2(REQ_DEPTH);
    localparam int REQ_CW    = REQ_AW + 1;

    // answer frame bookkeeping
    localparam int         ANS_CW       = 9;
    localparam logic [8:0] ANS_OVERHEAD = 9'd4;

    // configuration port
    localparam int         CFG_IDX_W   = 1;
    localparam int         CFG_DATA_W  = 16;
    localparam logic [0:0] CFG_MAX_LEN = 1'b0;
    localparam logic [0:0] CFG_TIMEOUT = 1'b1;

    localparam logic [7:0]  MAX_LEN_RESET = 8'd251;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [15:0] TICK_MAX      = 16'hFFFF;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_START = 2'd1,
        MODE_BYTE  = 2'd2,
        MODE_TICK  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_ECHO       = 3'd1,
        PH_ANSWER     = 3'd2,
        PH_COMPLETE   = 3'd3,
        PH_WRONG_ECHO = 3'd4,
        PH_LENGTH_ERR = 3'd5,
        PH_TIMEOUT    = 3'd6
    } t_phase;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
        logic       first_of_request;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic       answer_valid;
        logic [7:0] answer_byte;
        logic [7:0] answer_position;
        logic       answer_last;
    } t_out_item;

    // write request into the request store
    typedef struct packed {
        logic              we;
        logic [REQ_AW-1:0] addr;
        logic [7:0]        data;
    } t_store_wr;

endpackage

// ===== hdl/ccear_req_store.sv =====
// ----------------------------------------------------------------------------
// ccear_req_store
// Request byte store: one write and one registered read per cycle, with
// forwarding of a write that hits the address read in the same cycle.
// ----------------------------------------------------------------------------
module ccear_req_store
    import ccear_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_store_wr         i_wr,
    input  logic [REQ_AW-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);

    logic [7:0] r_mem [REQ_DEPTH];
    logic [7:0] r_rd_data;
    logic [7:0] r_fwd_data;
    logic       r_fwd;

    // storage array, read returns old contents
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data  <= r_mem[i_rd_addr];
        r_fwd_data <= i_wr.data;
    end

    // same-address write bypass flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else begin
            r_fwd <= i_wr.we && (i_wr.addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rd_data;

endmodule

// ===== hdl/ccear_ctrl.sv =====
// ----------------------------------------------------------------------------
// ccear_ctrl
// Receive controller: phase, counters, configuration registers and the
// output register. Prefetches the next echo byte from the request store.
// ----------------------------------------------------------------------------
module ccear_ctrl
    import ccear_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_store_wr             o_wr,
    output logic [REQ_AW-1:0]     o_rd_addr,
    input  logic [7:0]            i_rd_data
);

    t_phase            r_phase, n_phase;
    logic [REQ_CW-1:0] r_req_len, n_req_len;
    logic [REQ_CW-1:0] r_echo_cnt, n_echo_cnt;
    logic [ANS_CW-1:0] r_ans_cnt, n_ans_cnt;
    logic [7:0]        r_ans_len, n_ans_len;
    logic [15:0]       r_ticks, n_ticks;
    logic [7:0]        r_max_len;
    logic [15:0]       r_timeout;
    logic              r_out_valid;
    t_out_item         r_out, n_out;
    logic              accept;
    logic [REQ_CW-1:0] load_len;

    // no beat is taken while reset is held
    assign o_in_ready  = i_rst_n && (!r_out_valid || i_out_ready);
    assign o_cfg_ready = i_rst_n;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // next echo position is prefetched so its byte is ready next cycle
    assign o_rd_addr = n_echo_cnt[REQ_AW-1:0];

    // item processing
    always_comb begin
        n_phase    = r_phase;
        n_req_len  = r_req_len;
        n_echo_cnt = r_echo_cnt;
        n_ans_cnt  = r_ans_cnt;
        n_ans_len  = r_ans_len;
        n_ticks    = r_ticks;
        n_out      = '0;
        o_wr       = '0;
        load_len   = i_in_data.first_of_request ? '0 : r_req_len;
        if (accept) begin
            unique case (t_mode'(i_in_data.mode))
                MODE_LOAD: begin
                    if (load_len < REQ_CW'(REQ_DEPTH)) begin
                        o_wr.we   = 1'b1;
                        o_wr.addr = load_len[REQ_AW-1:0];
                        o_wr.data = i_in_data.data_byte;
                        n_req_len = load_len + 1'b1;
                    end else begin
                        n_req_len = load_len;
                    end
                    n_phase    = PH_IDLE;
                    n_echo_cnt = '0;
                    n_ans_cnt  = '0;
                    n_ans_len  = '0;
                    n_ticks    = '0;
                end
                MODE_START: begin
                    n_echo_cnt = '0;
                    n_ans_cnt  = '0;
                    n_ans_len  = '0;
                    n_ticks    = '0;
                    n_phase    = (r_req_len == '0) ? PH_ANSWER : PH_ECHO;
                end
                MODE_BYTE: begin
                    if (r_phase == PH_ECHO) begin
                        // line echo must match the stored request byte
                        if (r_echo_cnt >= r_req_len || i_rd_data != i_in_data.data_byte) begin
                            n_phase = PH_WRONG_ECHO;
                        end else begin
                            n_echo_cnt = r_echo_cnt + 1'b1;
                            if (n_echo_cnt == r_req_len) begin
                                n_phase = PH_ANSWER;
                            end
                        end
                    end else if (r_phase == PH_ANSWER) begin
                        if (r_ans_cnt == ANS_CW'(1) && i_in_data.data_byte > r_max_len) begin
                            n_phase = PH_LENGTH_ERR;
                        end else begin
                            if (r_ans_cnt == ANS_CW'(1)) begin
                                n_ans_len = i_in_data.data_byte;
                            end
                            n_out.answer_valid    = 1'b1;
                            n_out.answer_byte     = i_in_data.data_byte;
                            n_out.answer_position = r_ans_cnt[7:0];
                            // the length byte itself can never close the frame
                            if (r_ans_cnt != '0 && r_ans_cnt == {1'b0, r_ans_len} + ANS_OVERHEAD) begin
                                n_phase           = PH_COMPLETE;
                                n_out.answer_last = 1'b1;
                            end else begin
                                n_ans_cnt = r_ans_cnt + 1'b1;
                            end
                        end
                    end
                end
                MODE_TICK: begin
                    if (r_phase == PH_ECHO || r_phase == PH_ANSWER) begin
                        if (r_ticks != TICK_MAX) begin
                            n_ticks = r_ticks + 1'b1;
                        end
                        if (n_ticks >= r_timeout) begin
                            n_phase = PH_TIMEOUT;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        n_out.status = n_phase;
    end

    // state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_req_len  <= '0;
            r_echo_cnt <= '0;
            r_ans_cnt  <= '0;
            r_ans_len  <= '0;
            r_ticks    <= '0;
            r_max_len  <= MAX_LEN_RESET;
            r_timeout  <= TIMEOUT_RESET;
        end else begin
            r_phase    <= n_phase;
            r_req_len  <= n_req_len;
            r_echo_cnt <= n_echo_cnt;
            r_ans_cnt  <= n_ans_cnt;
            r_ans_len  <= n_ans_len;
            r_ticks    <= n_ticks;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MAX_LEN: r_max_len <= i_cfg_data[7:0];
                    CFG_TIMEOUT: r_timeout <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== hdl/cctalk_echo_and_answer_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// cctalk_echo_and_answer_receiver_unit
// Receive side of a half-duplex single-wire byte bus: echo check against
// the stored request, then answer frame collection with length and timeout.
// ----------------------------------------------------------------------------
// Takes one input beat per clock and returns exactly one registered result
// beat for each; the output register lets a new beat in while a result
// waits, so input only stalls when the result is not taken.
// The echo compare reads the request store through its single read port;
// the byte for the next echo position is prefetched, so the store sets no
// limit on rate. No clearing pass follows reset: store entries are only
// compared after they have been loaded.
module cctalk_echo_and_answer_receiver_unit
    import ccear_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_store_wr         wr;
    logic [REQ_AW-1:0] rd_addr;
    logic [7:0]        rd_data;

    ccear_req_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    ccear_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_wr        (wr),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

endmodule

// ===== hdl/ccear_checker.sv =====
// ----------------------------------------------------------------------------
// ccear_checker
// Port-level checks of the receiver: result beat holding, answer field
// consistency and the load response.
// ----------------------------------------------------------------------------
module ccear_checker
    import ccear_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // stalled result beat holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // no answer byte means all answer fields are zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.answer_valid |->
            o_out_data.answer_byte == 8'd0 && o_out_data.answer_position == 8'd0
            && !o_out_data.answer_last)
        else $error("answer fields set without an answer byte");

    // closing checksum completes the frame
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.answer_last |->
            o_out_data.answer_valid && o_out_data.status == PH_COMPLETE)
        else $error("last answer byte without completion");

    // answer bytes only while answering or on completion
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.answer_valid |->
            o_out_data.status == PH_ANSWER || o_out_data.status == PH_COMPLETE)
        else $error("answer byte in wrong phase");

    // loading a request byte answers with idle status next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.mode == MODE_LOAD |=>
            o_out_valid && o_out_data.status == PH_IDLE && !o_out_data.answer_valid)
        else $error("load beat did not return idle");

endmodule

bind cctalk_echo_and_answer_receiver_unit ccear_checker u_ccear_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the echo-and-answer receiver: directed tests for
// each corner of the echo and answer phases, then random request/answer
// traffic, with every result beat checked against an in-bench predictor.
// ----------------------------------------------------------------------------
module testbench;
    import ccear_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 90;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    cctalk_echo_and_answer_receiver_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor copy of the receiver state and registers
    logic [7:0]  req_mem [REQ_DEPTH];
    int          req_len   = 0;
    t_phase      rx_phase  = PH_IDLE;
    int          echo_idx  = 0;
    int          ans_idx   = 0;
    int          ans_len   = 0;
    int          tick_cnt  = 0;
    logic [7:0]  lim_len   = MAX_LEN_RESET;
    logic [15:0] lim_ticks = TIMEOUT_RESET;

    t_out_item   expected_answers [$];
    logic [7:0]  sent_request [$];
    int          err_count   = 0;
    int          items_sent  = 0;
    int          cycle_count = 0;
    int          tick_pct    = 0;
    bit          no_gaps     = 1'b0;
    int          stall_left  = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void clear_counters();
        echo_idx = 0;
        ans_idx  = 0;
        ans_len  = 0;
        tick_cnt = 0;
    endfunction

    // next status and answer byte for one accepted beat
    function automatic t_out_item predict_answer(t_in_item it);
        t_out_item r;
        r = '0;
        case (t_mode'(it.mode))
            MODE_LOAD: begin
                if (it.first_of_request) req_len = 0;
                if (req_len < REQ_DEPTH) begin
                    req_mem[req_len] = it.data_byte;
                    req_len++;
                end
                rx_phase = PH_IDLE;
                clear_counters();
            end
            MODE_START: begin
                clear_counters();
                rx_phase = (req_len == 0) ? PH_ANSWER : PH_ECHO;
            end
            MODE_BYTE: begin
                if (rx_phase == PH_ECHO) begin
                    if (echo_idx >= req_len || req_mem[echo_idx] != it.data_byte) begin
                        rx_phase = PH_WRONG_ECHO;
                    end else begin
                        echo_idx++;
                        if (echo_idx == req_len) rx_phase = PH_ANSWER;
                    end
                end else if (rx_phase == PH_ANSWER) begin
                    if (ans_idx == 1 && it.data_byte > lim_len) begin
                        rx_phase = PH_LENGTH_ERR;
                    end else begin
                        if (ans_idx == 1) ans_len = it.data_byte;
                        r.answer_valid    = 1'b1;
                        r.answer_byte     = it.data_byte;
                        r.answer_position = ans_idx[7:0];
                        if (ans_idx >= 1 && ans_idx == ans_len + int'(ANS_OVERHEAD)) begin
                            rx_phase      = PH_COMPLETE;
                            r.answer_last = 1'b1;
                        end else begin
                            ans_idx++;
                        end
                    end
                end
            end
            MODE_TICK: begin
                if (rx_phase == PH_ECHO || rx_phase == PH_ANSWER) begin
                    if (tick_cnt < int'(TICK_MAX)) tick_cnt++;
                    if (tick_cnt >= int'(lim_ticks)) rx_phase = PH_TIMEOUT;
                end
            end
        endcase
        r.status = rx_phase;
        return r;
    endfunction

    // result side: random stalls, checked on the falling edge before the taking edge
    always @(posedge clk) begin
        if (no_gaps) begin
            stall_left <= 0;
            out_ready  <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if ($urandom_range(0, 99) < 20) begin
            stall_left <= pick_gap();
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            err_count++;
        end
    endfunction

    always @(negedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_answers.size() == 0) begin
                $display("%0t: result beat with nothing expected: expected none, actual %p",
                         $time, out_data);
                err_count++;
            end else begin
                want = expected_answers.pop_front();
                check_field("status", 8'(want.status), 8'(out_data.status));
                check_field("answer_valid", 8'(want.answer_valid), 8'(out_data.answer_valid));
                check_field("answer_byte", want.answer_byte, out_data.answer_byte);
                check_field("answer_position", want.answer_position,
                            out_data.answer_position);
                check_field("answer_last", 8'(want.answer_last), 8'(out_data.answer_last));
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // one input beat; the prediction is taken at the accepting edge
    task automatic send_item(t_mode m, logic [7:0] b, logic f);
        t_in_item  it;
        t_out_item exp_item;
        int        gap;
        it  = '{mode: m, data_byte: b, first_of_request: f};
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        exp_item = predict_answer(it);
        expected_answers.insert(expected_answers.size(), exp_item);
        items_sent++;
        if (m == MODE_LOAD) begin
            if (f) sent_request.delete();
            if (sent_request.size() < REQ_DEPTH) begin
                sent_request.insert(sent_request.size(), b);
            end
        end
    endtask

    task automatic wait_all_answers();
        in_valid <= 1'b0;
        while (expected_answers.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        wait_all_answers();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_MAX_LEN) lim_len = val[7:0];
        else lim_ticks = val;
    endtask

    task automatic load_request(int n, bit fresh);
        for (int i = 0; i < n; i++) begin
            send_item(MODE_LOAD, 8'($urandom), fresh && i == 0);
        end
    endtask

    // a line byte, sometimes preceded by a timer tick
    task automatic send_line_byte(logic [7:0] b);
        if (tick_pct != 0 && $urandom_range(0, 99) < tick_pct) begin
            send_item(MODE_TICK, 8'($urandom), 1'($urandom));
        end
        send_item(MODE_BYTE, b, 1'($urandom));
    endtask

    // echo of the stored request; a bit flip at bad_pos ends it early
    task automatic send_echo(int bad_pos, int count);
        logic [7:0] b;
        for (int i = 0; i < count && i < sent_request.size(); i++) begin
            b = sent_request[i];
            if (i == bad_pos) begin
                b ^= 8'(1 << $urandom_range(0, 7));
                send_line_byte(b);
                return;
            end
            send_line_byte(b);
        end
    endtask

    // answer frame: destination, length, source, header, data, checksum
    task automatic send_frame(int dlen, int nbytes);
        for (int i = 0; i < nbytes; i++) begin
            send_line_byte((i == 1) ? 8'(dlen) : 8'($urandom));
        end
    endtask

    task automatic test_empty_request();
        send_item(MODE_BYTE, 8'hFF, 1'b1);
        send_item(MODE_TICK, 8'h00, 1'b0);
        send_item(MODE_START, 8'h00, 1'b0);
        send_item(MODE_BYTE, 8'h00, 1'b0);
        send_item(MODE_BYTE, 8'h00, 1'b0);
        send_item(MODE_BYTE, 8'hFF, 1'b1);
        send_item(MODE_BYTE, 8'h55, 1'b0);
        send_item(MODE_BYTE, 8'hAA, 1'b0);
        // frame is complete, these are ignored
        send_item(MODE_BYTE, 8'h12, 1'b0);
        send_item(MODE_TICK, 8'hFF, 1'b1);
    endtask

    task automatic test_basic_exchange();
        send_item(MODE_LOAD, 8'h02, 1'b1);
        send_item(MODE_LOAD, 8'h00, 1'b0);
        send_item(MODE_LOAD, 8'hFF, 1'b0);
        send_item(MODE_START, 8'hA5, 1'b1);
        send_echo(-1, REQ_DEPTH);
        send_frame(2, 7);
        send_item(MODE_BYTE, 8'h80, 1'b0);
        // start re-arms from complete; a load mid-answer drops back to idle
        send_item(MODE_START, 8'h00, 1'b0);
        send_echo(-1, REQ_DEPTH);
        send_frame(3, 3);
        send_item(MODE_LOAD, 8'h7E, 1'b1);
        send_item(MODE_START, 8'h00, 1'b0);
        send_echo(-1, REQ_DEPTH);
        send_frame(0, 5);
    endtask

    task automatic test_wrong_echo();
        load_request(4, 1'b1);
        send_item(MODE_START, 8'h00, 1'b0);
        send_echo(2, REQ_DEPTH);
        send_item(MODE_BYTE, 8'h00, 1'b0);
        send_item(MODE_TICK, 8'h00, 1'b0);
        send_item(MODE_START, 8'h00, 1'b0);
        send_echo(-1, REQ_DEPTH);
        send_frame(1, 6);
    endtask

    task automatic test_length_limit();
        write_reg(CFG_MAX_LEN, 16'd0);
        send_item(MODE_START, 8'h00, 1'b0);
        send_echo(-1, REQ_DEPTH);
        send_frame(1, 3);
        send_item(MODE_START, 8'h00, 1'b0);
        send_echo(-1, REQ_DEPTH);
        send_frame(0, 5);
        write_reg(CFG_MAX_LEN, 16'd251);
        send_item(MODE_START, 8'h00, 1'b0);
        send_echo(-1, REQ_DEPTH);
        send_frame(252, 3);
    endtask

    task automatic test_timeout();
        write_reg(CFG_TIMEOUT, 16'd1);
        send_item(MODE_START, 8'h00, 1'b0);
        send_item(MODE_TICK, 8'h00, 1'b0);
        send_item(MODE_TICK, 8'h00, 1'b0);
        // ticks spread over echo and answer
        write_reg(CFG_TIMEOUT, 16'd3);
        send_item(MODE_START, 8'h00, 1'b0);
        send_item(MODE_TICK, 8'h00, 1'b0);
        send_echo(-1, REQ_DEPTH);
        send_item(MODE_TICK, 8'h00, 1'b0);
        send_frame(4, 2);
        send_item(MODE_TICK, 8'h00, 1'b0);
        send_item(MODE_BYTE, 8'h00, 1'b0);
    endtask

    task automatic test_position_wrap();
        write_reg(CFG_MAX_LEN, 16'd255);
        load_request(1, 1'b1);
        send_item(MODE_START, 8'h00, 1'b0);
        send_echo(-1, REQ_DEPTH);
        send_frame(255, 260);
    endtask

    task automatic test_random_traffic();
        int base;
        int r;
        int cap;
        int dlen;
        int nbytes;
        bit first_pass;
        base       = items_sent;
        first_pass = 1'b1;
        while (items_sent - base < RANDOM_ITEMS) begin
            // new register settings now and then
            if (first_pass || $urandom_range(0, 99) < 12) begin
                case ($urandom_range(0, 4))
                    0: write_reg(CFG_MAX_LEN, 16'd0);
                    1: write_reg(CFG_MAX_LEN, 16'd251);
                    default: write_reg(CFG_MAX_LEN, 16'($urandom_range(1, 20)));
                endcase
                case ($urandom_range(0, 4))
                    0: write_reg(CFG_TIMEOUT, 16'd1);
                    1: write_reg(CFG_TIMEOUT, 16'($urandom_range(2, 12)));
                    2: write_reg(CFG_TIMEOUT, 16'($urandom_range(13, 60)));
                    3: write_reg(CFG_TIMEOUT, 16'd1000);
                    default: write_reg(CFG_TIMEOUT, 16'hFFFF);
                endcase
                case ($urandom_range(0, 2))
                    0: tick_pct = 0;
                    1: tick_pct = 5;
                    default: tick_pct = 15;
                endcase
                no_gaps    = ($urandom_range(0, 5) == 0);
                first_pass = 1'b0;
            end

            r = $urandom_range(0, 99);
            if (r >= 35 || sent_request.size() == 0) begin
                if (r < 85) load_request($urandom_range(1, 6), 1'b1);
                else if (r < 95) load_request($urandom_range(7, 24), 1'b1);
                else load_request($urandom_range(1, 3), 1'b0);
            end
            send_item(MODE_START, 8'($urandom), 1'($urandom));

            r = $urandom_range(0, 99);
            if (r < 82) send_echo(-1, REQ_DEPTH);
            else if (r < 92) send_echo($urandom_range(0, sent_request.size() - 1), REQ_DEPTH);
            else send_echo(-1, $urandom_range(0, sent_request.size() - 1));

            cap = (lim_len < 12) ? int'(lim_len) : 12;
            r   = $urandom_range(0, 99);
            if (r < 65) begin
                dlen   = $urandom_range(0, cap);
                nbytes = dlen + 5;
            end else if (r < 75) begin
                dlen   = (lim_len <= 40) ? int'(lim_len) : $urandom_range(0, cap);
                nbytes = dlen + 5;
            end else if (r < 88 && lim_len < 255) begin
                dlen   = $urandom_range(int'(lim_len) + 1, 255);
                nbytes = $urandom_range(2, 4);
            end else begin
                dlen   = $urandom_range(0, cap);
                nbytes = $urandom_range(0, dlen + 4);
            end
            send_frame(dlen, nbytes);

            // noise beats: stray bytes, ticks, loads and starts
            if ($urandom_range(0, 99) < 20) begin
                repeat ($urandom_range(1, 3)) begin
                    send_item(t_mode'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
                end
            end

            // hold off until the result side has caught up
            if ($urandom_range(0, 99) < 10) wait_all_answers();
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < REQ_DEPTH; i++) req_mem[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_request();
        test_basic_exchange();
        test_wrong_echo();
        test_length_limit();
        test_timeout();
        test_position_wrap();
        test_random_traffic();

        wait_all_answers();
        repeat (5) @(posedge clk);
        if (expected_answers.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_answers.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ccear_pkg.sv
hdl/ccear_req_store.sv
hdl/ccear_ctrl.sv
hdl/cctalk_echo_and_answer_receiver_unit.sv
hdl/ccear_checker.sv
bench/testbench.sv
